FILE: hdl/sha_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sha_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ============================================================================
package sha_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int BUF_AW    = 6;
    localparam int SCHED_AW  = 4;
    localparam int BCNT_W    = 61;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_LOADH,
        ST_RUN,
        ST_FOLD,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h [0:7];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

FILE: hdl/sha_core.sv
`timescale 1ns / 1ps
// ============================================================================
// sha_core
// One-round-per-step compression over a block memory and a schedule memory.
// ============================================================================
module sha_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [255:0]                 hin,
    output logic [sha_pkg::SCHED_AW-1:0] buf_raddr,
    input  logic [31:0]                  buf_rword,
    output logic [255:0]                 hout,
    output sha_pkg::core_ctl_t           ctl
);
    // buf_rword: registered 32-bit read of the block memory word at buf_raddr
    // each round runs as a schedule read phase, then a compute/write phase
    localparam int SHA_AWL = sha_pkg::SCHED_AW;
    logic [6:0]  rnd_reg, rnd_next;
    logic        ph_reg, ph_next;
    logic        busy_reg, busy_next;
    logic        done_reg;
    logic [31:0] v_reg [0:7];
    logic [31:0] sched_mem [0:15];
    logic [31:0] s15_q, s2_q, s16_q, s7_q;
    logic [31:0] w, s0, s1, t1, t2;
    logic [SHA_AWL-1:0] ri;

    assign ri = rnd_reg[SHA_AWL-1:0];
    assign buf_raddr = ri;

    always_ff @(posedge clk)
    begin
        s15_q <= sched_mem[ri - 4'd15];
        s2_q  <= sched_mem[ri - 4'd2];
        s16_q <= sched_mem[ri];
        s7_q  <= sched_mem[ri - 4'd7];
        if (busy_reg && ph_reg)
            sched_mem[ri] <= w;
    end

    always_comb
    begin
        s0 = sha_pkg::ror(s15_q, 7) ^ sha_pkg::ror(s15_q, 18) ^ (s15_q >> 3);
        s1 = sha_pkg::ror(s2_q, 17) ^ sha_pkg::ror(s2_q, 19) ^ (s2_q >> 10);
        w  = (rnd_reg < 7'd16) ? buf_rword : (s16_q + s0 + s7_q + s1);
        t1 = v_reg[7] + (sha_pkg::ror(v_reg[4], 6) ^ sha_pkg::ror(v_reg[4], 11)
             ^ sha_pkg::ror(v_reg[4], 25)) + ((v_reg[4] & v_reg[5]) ^
             (~v_reg[4] & v_reg[6])) + sha_pkg::round_k(rnd_reg[5:0]) + w;
        t2 = (sha_pkg::ror(v_reg[0], 2) ^ sha_pkg::ror(v_reg[0], 13) ^
             sha_pkg::ror(v_reg[0], 22)) + ((v_reg[0] & v_reg[1]) ^
             (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        rnd_next  = rnd_reg;
        ph_next   = ph_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rnd_next  = '0;
            ph_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            ph_next = ~ph_reg;
            if (ph_reg)
            begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'd63)
                    busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= '0;
            ph_reg   <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rnd_reg  <= rnd_next;
            ph_reg   <= ph_next;
            busy_reg <= busy_next;
            done_reg <= busy_reg && !busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= hin[255-32*i -: 32];
        end
        else if (busy_reg && ph_reg)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            hout[255-32*i -: 32] = hin[255-32*i -: 32] + v_reg[i];
    end

    assign ctl = '{start: start, busy: busy_reg, done: done_reg};

    a_nostart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("start while busy");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(rnd_reg) == 7'd63) else $error("bad done");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rnd_reg < 7'd64) else $error("round overrun");
endmodule

FILE: hdl/sha256_stream_hash.sv
`timescale 1ns / 1ps
// ============================================================================
// sha256_stream_hash
// Byte-stream SHA-256 hasher with padding and eight-word digest output.
// ============================================================================
// Bytes are taken one per cycle while idle; every 64th byte starts a
// compression (a load step, 64 rounds on the schedule memory, a step to
// see the rounds finish, and the fold), with the input held off.
// A final item adds the pad bytes one per cycle outside compressions, one
// or two compressions, then eight digest words one per accepted output.
module sha256_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    sha_pkg::ctrl_state_t st_reg, st_next;
    logic [6:0]   fill_reg, fill_next;
    logic [60:0]  bcnt_reg, bcnt_next;
    logic [255:0] h_reg;
    logic [255:0] hout;
    logic         fin_reg, fin_next;
    logic [3:0]   pidx_reg, pidx_next;
    logic [2:0]   oidx_reg, oidx_next;
    logic [31:0]  buf_mem [0:15];
    logic         wr_en;
    logic [7:0]   wr_byte;
    logic [3:0]   craddr;
    logic [31:0]  rword;
    logic         cstart;
    logic         load_init;
    logic         fold;
    logic [63:0]  bits;
    sha_pkg::core_ctl_t cctl;
    // pad begun: after fold, pad goes on until the length is in, then digest
    logic         pad_active_reg;

    assign bits = {bcnt_reg, 3'b000};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[fill_reg[5:2]][31 - 8*fill_reg[1:0] -: 8] <= wr_byte;
        rword <= buf_mem[craddr];
    end

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .start(cstart), .hin(h_reg),
        .buf_raddr(craddr), .buf_rword(rword), .hout(hout), .ctl(cctl));

    always_comb
    begin
        st_next   = st_reg;
        fill_next = fill_reg;
        bcnt_next = bcnt_reg;
        fin_next  = fin_reg;
        pidx_next = pidx_reg;
        oidx_next = oidx_reg;
        wr_en     = 1'b0;
        wr_byte   = data_byte;
        cstart    = 1'b0;
        load_init = 1'b0;
        fold      = 1'b0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (st_reg)
            sha_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    fin_next = end_of_message;
                    if (byte_present)
                    begin
                        wr_en = 1'b1;
                        bcnt_next = bcnt_reg + 61'd1;
                        fill_next = fill_reg + 7'd1;
                        if (fill_reg == 7'd63)
                            st_next = sha_pkg::ST_LOADH;
                        else if (end_of_message)
                            st_next = sha_pkg::ST_PAD80;
                    end
                    else if (end_of_message)
                        st_next = sha_pkg::ST_PAD80;
                end
            end
            sha_pkg::ST_PAD80:
            begin
                wr_en = 1'b1;
                wr_byte = 8'h80;
                fill_next = fill_reg + 7'd1;
                fin_next = 1'b0;
                pidx_next = '0;
                if (fill_reg == 7'd63)
                    st_next = sha_pkg::ST_LOADH;
                else if (fill_reg == 7'd55)
                    st_next = sha_pkg::ST_PADLEN;
                else
                    st_next = sha_pkg::ST_PADZ;
            end
            sha_pkg::ST_PADZ:
            begin
                wr_en = 1'b1;
                wr_byte = 8'h00;
                fill_next = fill_reg + 7'd1;
                if (fill_reg == 7'd63)
                    st_next = sha_pkg::ST_LOADH;
                else if (fill_reg == 7'd55)
                    st_next = sha_pkg::ST_PADLEN;
            end
            sha_pkg::ST_PADLEN:
            begin
                wr_en = 1'b1;
                wr_byte = bits[63 - 8*pidx_reg[2:0] -: 8];
                fill_next = fill_reg + 7'd1;
                pidx_next = pidx_reg + 4'd1;
                if (fill_reg == 7'd63)
                    st_next = sha_pkg::ST_LOADH;
            end
            sha_pkg::ST_LOADH:
            begin
                cstart = 1'b1;
                fill_next = '0;
                st_next = sha_pkg::ST_RUN;
            end
            sha_pkg::ST_RUN:
            begin
                if (cctl.done)
                    st_next = sha_pkg::ST_FOLD;
            end
            sha_pkg::ST_FOLD:
            begin
                fold = 1'b1;
                if (fin_reg)
                    st_next = sha_pkg::ST_PAD80;
                else if (pad_active_reg && !pidx_reg[3])
                    st_next = sha_pkg::ST_PADZ;
                else if (pad_active_reg)
                    st_next = sha_pkg::ST_OUT;
                else
                    st_next = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        load_init = 1'b1;
                        fill_next = '0;
                        bcnt_next = '0;
                        st_next = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: st_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= sha_pkg::ST_IDLE;
            fill_reg <= '0;
            bcnt_reg <= '0;
            fin_reg  <= 1'b0;
            pidx_reg <= '0;
            oidx_reg <= '0;
            pad_active_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[255-32*i -: 32] <= sha_pkg::init_hash(3'(i));
        end
        else
        begin
            fill_reg <= fill_next;
            bcnt_reg <= bcnt_next;
            fin_reg  <= fin_next;
            pidx_reg <= pidx_next;
            oidx_reg <= oidx_next;
            if (st_reg == sha_pkg::ST_PAD80)
                pad_active_reg <= 1'b1;
            else if (load_init)
                pad_active_reg <= 1'b0;
            st_reg <= st_next;
            if (fold)
                h_reg <= hout;
            else if (load_init)
                for (int i = 0; i < 8; i++)
                    h_reg[255-32*i -: 32] <= sha_pkg::init_hash(3'(i));
        end
    end

    assign digest_word = h_reg[255 - 32*oidx_reg -: 32];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);

    a_in_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("in and out together");
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == sha_pkg::ST_IDLE |-> fill_reg < 7'd64) else $error("fill");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_index))
        else $error("out dropped");
endmodule
